@@ rtl/crc_eng_pkg.sv @@
package crc_eng_pkg;

    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CRC_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY8      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLY32     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_XOR_OUT    = 3'd4;

    // crc_mode codes
    localparam logic [1:0] MODE_CRC8_MSB  = 2'd0;
    localparam logic [1:0] MODE_CRC8_REF  = 2'd1;
    localparam logic [1:0] MODE_CRC32_REF = 2'd2;
    localparam logic [1:0] MODE_CRC32_MSB = 2'd3;

    localparam logic [1:0]  CRC_MODE_RST   = MODE_CRC32_REF;
    localparam logic [7:0]  POLY8_RST      = 8'hD5;
    localparam logic [31:0] POLY32_RST     = 32'h04C11DB7;
    localparam logic [31:0] INIT_VALUE_RST = 32'hFFFFFFFF;
    localparam logic [31:0] XOR_OUT_RST    = 32'hFFFFFFFF;

    typedef struct packed {
        logic [1:0]  crc_mode;
        logic [7:0]  poly8;
        logic [31:0] poly32;
        logic [31:0] init_value;
        logic [31:0] xor_out;
    } cfg_t;

endpackage

@@ rtl/crc_eng_cfg.sv @@
module crc_eng_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [crc_eng_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                       cfg_data,
    output crc_eng_pkg::cfg_t                 cfg
);
    import crc_eng_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_CRC_MODE:   cfg_next.crc_mode   = cfg_data[1:0];
                REG_POLY8:      cfg_next.poly8      = cfg_data[7:0];
                REG_POLY32:     cfg_next.poly32     = cfg_data;
                REG_INIT_VALUE: cfg_next.init_value = cfg_data;
                REG_XOR_OUT:    cfg_next.xor_out    = cfg_data;
                default:        cfg_next = cfg_reg;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_mode   <= CRC_MODE_RST;
            cfg_reg.poly8      <= POLY8_RST;
            cfg_reg.poly32     <= POLY32_RST;
            cfg_reg.init_value <= INIT_VALUE_RST;
            cfg_reg.xor_out    <= XOR_OUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/crc_eng_fold.sv @@
module crc_eng_fold (
    input  crc_eng_pkg::cfg_t cfg,
    input  logic [7:0]        data_byte,
    input  logic              first_byte,
    input  logic [31:0]       crc_in,
    output logic [31:0]       crc_next,
    output logic [31:0]       crc_out
);
    import crc_eng_pkg::*;

    logic [7:0]  p8_ref;
    logic [31:0] p32_ref;
    logic [31:0] seed;
    logic [7:0]  c8;
    logic [31:0] c32;
    logic        narrow;

    // bit-reversed generators for the reflected modes
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            p8_ref[k] = cfg.poly8[7-k];
        end
        for (int k = 0; k < 32; k++) begin
            p32_ref[k] = cfg.poly32[31-k];
        end
    end

    always_comb begin
        narrow = ~cfg.crc_mode[1];
        seed   = first_byte ? cfg.init_value : crc_in;
        c8     = seed[7:0] ^ data_byte;
        c32    = seed;
        case (cfg.crc_mode)
            MODE_CRC8_MSB: begin
                for (int k = 0; k < 8; k++) begin
                    c8 = c8[7] ? ({c8[6:0], 1'b0} ^ cfg.poly8) : {c8[6:0], 1'b0};
                end
                c32 = {24'd0, c8};
            end
            MODE_CRC8_REF: begin
                for (int k = 0; k < 8; k++) begin
                    c8 = c8[0] ? ({1'b0, c8[7:1]} ^ p8_ref) : {1'b0, c8[7:1]};
                end
                c32 = {24'd0, c8};
            end
            MODE_CRC32_REF: begin
                c32 = seed ^ {24'd0, data_byte};
                for (int k = 0; k < 8; k++) begin
                    c32 = c32[0] ? ({1'b0, c32[31:1]} ^ p32_ref) : {1'b0, c32[31:1]};
                end
            end
            MODE_CRC32_MSB: begin
                c32 = seed ^ {data_byte, 24'd0};
                for (int k = 0; k < 8; k++) begin
                    c32 = c32[31] ? ({c32[30:0], 1'b0} ^ cfg.poly32) : {c32[30:0], 1'b0};
                end
            end
            default: c32 = seed;
        endcase
        crc_next = c32;
        crc_out  = narrow ? {24'd0, c32[7:0] ^ cfg.xor_out[7:0]} : (c32 ^ cfg.xor_out);
    end

endmodule

@@ rtl/configurable_crc8_crc32_engine_top.sv @@
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_data_byte[7:0], s_first_byte, s_last_byte
// m_        out        m_valid / m_ready      m_crc_result[31:0]
// cfg_      in         cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[31:0]
//
// One byte per clock unless a last byte waits on m_ready; m_valid rises once the input
// register folds a last byte. The clock is set by the eight-step shift/XOR byte fold.
// Synchronous active-low reset loads the register defaults and clears the running CRC.
// A last byte waits in the input register while an earlier result is not taken, and
// s_ready drops with it; bytes without the end mark never wait on m_ready. cfg_ready is
// always high.
module configurable_crc8_crc32_engine_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_first_byte,
    input  logic                              s_last_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [31:0]                       m_crc_result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crc_eng_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                       cfg_data
);
    import crc_eng_pkg::*;

    cfg_t        cfg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_data_reg;
    logic        in_first_reg;
    logic        in_last_reg;
    logic [31:0] running_crc_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_out;
    logic        out_free;
    logic        fold_go;

    assign cfg_ready = 1'b1;

    crc_eng_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crc_eng_fold u_fold (
        .cfg        (cfg),
        .data_byte  (in_data_reg),
        .first_byte (in_first_reg),
        .crc_in     (running_crc_reg),
        .crc_next   (crc_next),
        .crc_out    (crc_out)
    );

    assign out_free = !out_valid_reg || m_ready;
    // only a last byte needs the result slot
    assign fold_go  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || fold_go;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fold_go) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fold_go && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            running_crc_reg <= 32'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fold_go) begin
                running_crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
            in_last_reg  <= s_last_byte;
        end
        if (fold_go && in_last_reg) begin
            out_crc_reg <= crc_out;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_crc_result = out_crc_reg;

    // narrow modes keep the upper CRC bits clear
    a_narrow_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fold_go && !cfg.crc_mode[1] |=> running_crc_reg[31:8] == 24'd0)
        else $error("running CRC upper bits set in CRC-8 mode");

    // a pending result is never overwritten
    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !(fold_go && in_last_reg))
        else $error("result overwritten while stalled");

    a_crc_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fold_go |=> $stable(running_crc_reg))
        else $error("running CRC changed without a byte");

endmodule

@@ tb/sv/tb_configurable_crc8_crc32_engine_top.sv @@
`timescale 1ns / 100ps

module tb_configurable_crc8_crc32_engine_top;
    import crc_eng_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 600;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_data_byte = '0;
    logic                 s_first_byte = 1'b0;
    logic                 s_last_byte = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [31:0]          m_crc_result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // shadow of the register file and of the running CRC
    cfg_t        cur_cfg;
    logic [31:0] crc_state = '0;
    logic [31:0] pending_crcs [$];

    bit steady = 1'b0;  // no idling on either side while set
    int errors = 0;
    int n_bytes = 0;
    int n_results = 0;
    int n_cfg_writes = 0;
    int idle_cycles = 0;

    configurable_crc8_crc32_engine_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_first_byte (s_first_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_crc_result (m_crc_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic cfg_t default_cfg();
        cfg_t c;
        c.crc_mode   = CRC_MODE_RST;
        c.poly8      = POLY8_RST;
        c.poly32     = POLY32_RST;
        c.init_value = INIT_VALUE_RST;
        c.xor_out    = XOR_OUT_RST;
        return c;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return POLY32_RST;
            default: return $urandom;
        endcase
    endfunction

    // one byte through the eight shift/XOR stages of the selected variant
    function automatic logic [31:0] crc_after_byte(input logic [31:0] crc, input logic [7:0] b,
                                                   input cfg_t c);
        logic [31:0] r;
        logic [31:0] p;
        p = '0;
        case (c.crc_mode)
            MODE_CRC8_MSB: begin
                r = {24'h0, crc[7:0] ^ b};
                for (int k = 0; k < 8; k++)
                    r = r[7] ? (((r << 1) ^ {24'h0, c.poly8}) & 32'hFF) : ((r << 1) & 32'hFF);
            end
            MODE_CRC8_REF: begin
                for (int k = 0; k < 8; k++)
                    p[k] = c.poly8[7-k];
                r = {24'h0, crc[7:0] ^ b};
                for (int k = 0; k < 8; k++)
                    r = r[0] ? ((r >> 1) ^ p) : (r >> 1);
            end
            MODE_CRC32_REF: begin
                for (int k = 0; k < 32; k++)
                    p[k] = c.poly32[31-k];
                r = crc ^ {24'h0, b};
                for (int k = 0; k < 8; k++)
                    r = r[0] ? ((r >> 1) ^ p) : (r >> 1);
            end
            default: begin
                r = crc ^ {b, 24'h0};
                for (int k = 0; k < 8; k++)
                    r = r[31] ? ((r << 1) ^ c.poly32) : (r << 1);
            end
        endcase
        return r;
    endfunction

    task automatic predict_byte(input logic [7:0] d, input logic first, input logic last);
        logic        narrow;
        logic [31:0] base;
        narrow = (cur_cfg.crc_mode == MODE_CRC8_MSB) || (cur_cfg.crc_mode == MODE_CRC8_REF);
        base = first ? cur_cfg.init_value : crc_state;
        if (narrow)
            base = base & 32'hFF;
        crc_state = crc_after_byte(base, d, cur_cfg);
        if (last)
            pending_crcs.push_back(narrow ? ((crc_state ^ cur_cfg.xor_out) & 32'hFF)
                                          : (crc_state ^ cur_cfg.xor_out));
    endtask

    task automatic send_byte(input logic [7:0] d, input logic first, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= d;
        s_first_byte <= first;
        s_last_byte  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(d, first, last);
        n_bytes++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_CRC_MODE:   cur_cfg.crc_mode   = val[1:0];
            REG_POLY8:      cur_cfg.poly8      = val[7:0];
            REG_POLY32:     cur_cfg.poly32     = val;
            REG_INIT_VALUE: cur_cfg.init_value = val;
            REG_XOR_OUT:    cur_cfg.xor_out    = val;
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    // all five registers, back to back; call only with the engine idle
    task automatic load_config(input cfg_t c);
        write_reg(REG_CRC_MODE, {30'h0, c.crc_mode});
        write_reg(REG_POLY8, {24'h0, c.poly8});
        write_reg(REG_POLY32, c.poly32);
        write_reg(REG_INIT_VALUE, c.init_value);
        write_reg(REG_XOR_OUT, c.xor_out);
        cfg_valid <= 1'b0;
    endtask

    // hold off requests until every CRC is out, then let the pipeline empty
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_crcs.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic test_after_reset();
        // unmarked bytes fold into the cleared register, default CRC-32 reflected
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_each_mode();
        cfg_t       c;
        logic [1:0] modes [4];
        modes[0] = MODE_CRC8_MSB;
        modes[1] = MODE_CRC8_REF;
        modes[2] = MODE_CRC32_REF;
        modes[3] = MODE_CRC32_MSB;
        for (int i = 0; i < 4; i++) begin
            c = default_cfg();
            c.crc_mode = modes[i];
            load_config(c);
            send_byte(8'hFF, 1'b1, 1'b1);
            // keeps folding from the unmasked value after the end mark
            send_byte(8'h00, 1'b0, 1'b1);
            drain();
        end
    endtask

    task automatic test_mode_switch();
        cfg_t c;
        c = default_cfg();
        c.crc_mode = MODE_CRC32_MSB;
        load_config(c);
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        drain();
        // wide value cut to its low byte
        c.crc_mode = MODE_CRC8_REF;
        load_config(c);
        send_byte(8'h56, 1'b0, 1'b1);
        drain();
        c.crc_mode = MODE_CRC8_MSB;
        load_config(c);
        send_byte(8'h78, 1'b1, 1'b0);
        drain();
        c.crc_mode = MODE_CRC32_REF;
        load_config(c);
        send_byte(8'h9A, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_config_extremes();
        cfg_t c;
        c.poly8      = 8'h00;
        c.poly32     = 32'h0;
        c.init_value = 32'h0;
        c.xor_out    = 32'h0;
        c.crc_mode   = MODE_CRC8_MSB;
        load_config(c);
        send_byte(8'hFF, 1'b1, 1'b1);
        drain();
        c.crc_mode = MODE_CRC32_REF;
        load_config(c);
        send_byte(8'h80, 1'b1, 1'b1);
        drain();
        c.poly8      = 8'hFF;
        c.poly32     = 32'hFFFFFFFF;
        c.init_value = 32'hFFFFFFFF;
        c.xor_out    = 32'hFFFFFFFF;
        c.crc_mode   = MODE_CRC8_REF;
        load_config(c);
        send_byte(8'h01, 1'b1, 1'b1);
        drain();
        c.crc_mode = MODE_CRC32_MSB;
        load_config(c);
        send_byte(8'h7F, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_random_traffic();
        cfg_t c;
        int   sent;
        int   len;
        bit   cut;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            drain();
            c.crc_mode   = 2'($urandom_range(0, 3));
            c.poly8      = ($urandom_range(0, 3) == 0) ? POLY8_RST : 8'(pick_word());
            c.poly32     = pick_word();
            c.init_value = pick_word();
            c.xor_out    = pick_word();
            load_config(c);
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 8)) begin
                if ($urandom_range(0, 9) == 0) begin
                    // stray request with arbitrary marks
                    send_byte(8'($urandom), 1'($urandom), 1'($urandom));
                    sent++;
                end else begin
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8);
                    cut = ($urandom_range(0, 9) == 0);
                    for (int k = 0; k < len; k++) begin
                        send_byte(8'($urandom), k == 0, (k == len - 1) && !cut);
                        sent++;
                    end
                end
            end
        end
        steady = 1'b0;
        drain();
    endtask

    // result side: random stalls, compare with the oldest predicted CRC
    initial begin
        int          stall;
        logic [31:0] want;
        wait (aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            n_results++;
            if (pending_crcs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: crc_result=%08h", m_crc_result);
            end else begin
                want = pending_crcs.pop_front();
                if (m_crc_result !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: crc_result expected %08h, got %08h",
                                 want, m_crc_result);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        cur_cfg = default_cfg();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_each_mode();
        test_mode_switch();
        test_config_extremes();
        test_random_traffic();

        s_valid <= 1'b0;
        while (pending_crcs.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d bytes sent, %0d CRCs checked, %0d register writes", n_bytes, n_results,
                 n_cfg_writes);
        $display("covered all four CRC variants, mid-message mode changes, extreme settings");
        if (errors == 0 && pending_crcs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
